// ===== sv/mf3_pkg.sv =====
package mf3_pkg;

  // field widths fixed by the stream format
  localparam int unsigned PixelW = 8;
  localparam int unsigned PosW   = 11;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned SumW   = 12;

  // register indexes on the configuration port
  localparam logic CfgFrameWidth  = 1'b0;
  localparam logic CfgFrameHeight = 1'b1;

  localparam logic [CfgW-1:0] FrameWidthRst  = 12'd640;
  localparam logic [CfgW-1:0] FrameHeightRst = 12'd480;

  // floor(sum / 9) as (sum * 7282) >> 16, exact for sums up to 9 * 255
  localparam int unsigned     RecipW     = 13;
  localparam logic [RecipW-1:0] RecipNine = 13'd7282;
  localparam int unsigned     RecipShift = 16;
  localparam int unsigned     ProdW      = SumW + RecipW;

  // result queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  localparam int unsigned TdataOutW = 32;

  typedef struct packed {
    logic [PixelW-1:0] upper;
    logic [PixelW-1:0] middle;
  } line_pair_t;

  typedef struct packed {
    logic              last;
    logic [PosW-1:0]   col;
    logic [PosW-1:0]   row;
    logic [PixelW-1:0] mean;
  } result_t;

endpackage

// ===== sv/mf3_line_store.sv =====
module mf3_line_store #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned AddrW = 11
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  mf3_pkg::line_pair_t wr_data_i,
  output mf3_pkg::line_pair_t rd_data_o
);
  import mf3_pkg::*;

  line_pair_t mem_q [Depth];
  line_pair_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // a read of the entry being written this cycle returns the new data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/mean_filter_3x3.sv =====
// 3x3 mean filter over a raster-order greyscale pixel stream
// path: pixel transfer, stage 1, stage 2, result queue, then offered on the master side
// throughput: one pixel per clock, held only by back-pressure on the result stream
// the line store pair is one read and one write per cycle; that port pair sets the rate
// reset (async, active low): position counters, window, pipeline and result queue cleared,
// frame size back to 640 x 480; line stores keep their contents and are not cleared
module mean_filter_3x3 #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [mf3_pkg::CfgW-1:0]      cfg_data_i,
  // pixel stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mf3_pkg::PixelW-1:0]    s_axis_tdata,  // [7:0] pixel
  input  logic                          s_axis_tuser,  // [0] frame_start
  // result stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mf3_pkg::TdataOutW-1:0] m_axis_tdata,  // [7:0] mean_value, [18:8] out_row,
                                                       // [29:19] out_col, [31:30] zero
  output logic                          m_axis_tlast   // frame_last
);
  import mf3_pkg::*;

  // column counter and line store address width, row counter width, and width of clamped sizes
  localparam int unsigned ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned DimWW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DimHW = $clog2(MAX_HEIGHT + 1);
  // compare width for clamping the raw register against the maximum
  localparam int unsigned ClWW  = (DimWW > CfgW) ? DimWW : CfgW;
  localparam int unsigned ClHW  = (DimHW > CfgW) ? DimHW : CfgW;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CfgW-1:0] frame_width_q, frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFrameWidth:  frame_width_q  <= cfg_data_i;
        CfgFrameHeight: frame_height_q <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // effective sizes: below 3 act as 3, above the maximum act as the maximum
  logic [DimWW-1:0] eff_w;
  logic [DimHW-1:0] eff_h;

  always_comb begin
    if (frame_width_q < CfgW'(3)) begin
      eff_w = DimWW'(3);
    end else if (ClWW'(frame_width_q) > ClWW'(MAX_WIDTH)) begin
      eff_w = DimWW'(MAX_WIDTH);
    end else begin
      eff_w = DimWW'(frame_width_q);
    end
    if (frame_height_q < CfgW'(3)) begin
      eff_h = DimHW'(3);
    end else if (ClHW'(frame_height_q) > ClHW'(MAX_HEIGHT)) begin
      eff_h = DimHW'(MAX_HEIGHT);
    end else begin
      eff_h = DimHW'(frame_height_q);
    end
  end

  // ---------------------------------------------------------------------------
  // input stage: position tracking and line store read
  // ---------------------------------------------------------------------------
  logic            in_xfer;
  logic [ColW-1:0] col_q, col_d, pos_c;
  logic [RowW-1:0] row_q, row_d, pos_r;
  logic            pos_emit, pos_last;

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // frame_start puts this pixel at the frame origin
  assign pos_c = s_axis_tuser ? '0 : col_q;
  assign pos_r = s_axis_tuser ? '0 : row_q;

  // a pixel at row >= 2 and column >= 2 closes the window around (r-1, c-1)
  assign pos_emit = (pos_r >= RowW'(2)) && (pos_c >= ColW'(2));
  assign pos_last = (DimHW'(pos_r) == eff_h - DimHW'(1)) &&
                    (DimWW'(pos_c) == eff_w - DimWW'(1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_xfer) begin
      if (DimWW'(pos_c) + DimWW'(1) >= eff_w) begin
        col_d = '0;
        row_d = (DimHW'(pos_r) + DimHW'(1) >= eff_h) ? '0 : pos_r + RowW'(1);
      end else begin
        col_d = pos_c + ColW'(1);
        row_d = pos_r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1 holds the pixel while its line store entry (upper and middle pixels) is read
  logic              s1_valid_q;
  logic              s1_emit_q;
  logic              s1_last_q;
  logic [PixelW-1:0] s1_px_q;
  logic [ColW-1:0]   s1_addr_q;
  logic [PosW-1:0]   s1_row_q, s1_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_xfer;
      s1_emit_q  <= in_xfer && pos_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_px_q   <= s_axis_tdata;
      s1_addr_q <= pos_c;
      s1_row_q  <= PosW'(pos_r - RowW'(1));
      s1_col_q  <= PosW'(pos_c - ColW'(1));
      s1_last_q <= pos_last;
    end
  end

  // ---------------------------------------------------------------------------
  // line stores: upper (row r-2) and middle (row r-1) kept side by side
  // ---------------------------------------------------------------------------
  line_pair_t lines_rd, lines_wr;

  // the old middle entry moves up, the new pixel becomes the middle entry
  assign lines_wr.upper  = lines_rd.middle;
  assign lines_wr.middle = s1_px_q;

  mf3_line_store #(
    .Depth (MAX_WIDTH),
    .AddrW (ColW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_xfer),
    .rd_addr_i (pos_c),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (lines_wr),
    .rd_data_o (lines_rd)
  );

  // ---------------------------------------------------------------------------
  // window shift and nine-pixel sum
  // ---------------------------------------------------------------------------
  // row-major, column 2 is the newest
  logic [PixelW-1:0] win_q [9];
  logic [PixelW-1:0] win_d [9];
  logic [SumW-1:0]   win_sum;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k*3]     = win_q[k*3 + 1];
      win_d[k*3 + 1] = win_q[k*3 + 2];
    end
    win_d[2] = lines_rd.upper;
    win_d[5] = lines_rd.middle;
    win_d[8] = s1_px_q;
  end

  always_comb begin
    win_sum = '0;
    for (int k = 0; k < 9; k++) begin
      win_sum = win_sum + SumW'(win_d[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (s1_valid_q) begin
      win_q <= win_d;
    end
  end

  // stage 2 holds the sum of an emitting window
  logic            s2_valid_q;
  logic            s2_last_q;
  logic [SumW-1:0] s2_sum_q;
  logic [PosW-1:0] s2_row_q, s2_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_emit_q) begin
      s2_sum_q  <= win_sum;
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;
      s2_last_q <= s1_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // divide by nine through a reciprocal multiply, then into the result queue
  // ---------------------------------------------------------------------------
  logic [ProdW-1:0] mean_prod;
  result_t          res_new;

  assign mean_prod    = ProdW'(s2_sum_q) * ProdW'(RecipNine);
  assign res_new.mean = mean_prod[RecipShift +: PixelW];
  assign res_new.row  = s2_row_q;
  assign res_new.col  = s2_col_q;
  assign res_new.last = s2_last_q;

  result_t               res_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]   count_q, in_flight;
  logic                  out_xfer;

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      res_q[wr_ptr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (s2_valid_q) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (out_xfer) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      count_q <= count_q + FifoCntW'(s2_valid_q) - FifoCntW'(out_xfer);
    end
  end

  // results still in the pipe reserve a queue slot before a pixel is taken
  assign in_flight     = count_q + FifoCntW'(s1_emit_q) + FifoCntW'(s2_valid_q);
  assign s_axis_tready = in_flight < FifoCntW'(FifoDepth);

  assign m_axis_tvalid = count_q != '0;
  assign m_axis_tdata  = {{(TdataOutW - 2*PosW - PixelW){1'b0}},
                          res_q[rd_ptr_q].col, res_q[rd_ptr_q].row, res_q[rd_ptr_q].mean};
  assign m_axis_tlast  = res_q[rd_ptr_q].last;

endmodule

// ===== sv/mf3_checker.sv =====
module mf3_sva (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mf3_pkg::TdataOutW-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);

  // nothing offered in the cycle after a reset edge
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result offered during reset");

  // the pixel side only stalls when results are backed up
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  // a fresh result follows a pixel transfer by the pipeline depth
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3))
    else $error("result appeared without a matching pixel transfer");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

endmodule

bind mean_filter_3x3 mf3_sva u_mf3_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
